/* hw/rtl/tfcc_pkg.sv */
// ---------------------------------------------------------------------------
// tfcc_pkg
// Shared constants, types and the CRC-16 byte update for the frame checker.
// ---------------------------------------------------------------------------
package tfcc_pkg;

	localparam int FRAME_BYTES = 12;
	localparam int CRC_SPAN    = FRAME_BYTES - 2;
	localparam int POS_SAT     = FRAME_BYTES + 1;
	localparam int POS_W       = $clog2(POS_SAT + 1);

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// byte offsets inside a frame
	localparam logic [POS_W-1:0] POS_ID    = POS_W'(3);
	localparam logic [POS_W-1:0] POS_SEQ_H = POS_W'(4);
	localparam logic [POS_W-1:0] POS_SEQ_L = POS_W'(5);
	localparam logic [POS_W-1:0] POS_VLT_H = POS_W'(6);
	localparam logic [POS_W-1:0] POS_VLT_L = POS_W'(7);
	localparam logic [POS_W-1:0] POS_TMP_H = POS_W'(8);
	localparam logic [POS_W-1:0] POS_TMP_L = POS_W'(9);
	localparam logic [POS_W-1:0] POS_CRC_H = POS_W'(10);
	localparam logic [POS_W-1:0] POS_CRC_L = POS_W'(11);
	localparam logic [POS_W-1:0] POS_LAST  = POS_W'(FRAME_BYTES - 1);

	typedef enum logic [1:0] {
		ST_GOOD    = 2'd0,
		ST_CRC_ERR = 2'd1,
		ST_BAD_LEN = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0]  rx_byte;
		logic        end_of_packet;
	} in_item_t;

	typedef struct packed {
		status_t            status;
		logic [7:0]         sender_id;
		logic [15:0]        sequence_res;
		logic signed [15:0] voltage_x100;
		logic signed [15:0] temperature_x100;
		logic [15:0]        received_check;
		logic [15:0]        computed_check;
		logic [31:0]        good_count;
		logic [31:0]        bad_count;
	} result_t;

	// reflected CRC-16, eight shifts unrolled for one byte
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

/* hw/rtl/tfcc_if.sv */
// ---------------------------------------------------------------------------
// tfcc_if
// Valid/ready channels for received bytes and for frame results.
// ---------------------------------------------------------------------------
interface tfcc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       end_of_packet;

	modport source (output valid, rx_byte, end_of_packet, input ready);
	modport sink   (input valid, rx_byte, end_of_packet, output ready);
endinterface

interface tfcc_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic [7:0]         sender_id;
	logic [15:0]        sequence_res;
	logic signed [15:0] voltage_x100;
	logic signed [15:0] temperature_x100;
	logic [15:0]        received_check;
	logic [15:0]        computed_check;
	logic [31:0]        good_count;
	logic [31:0]        bad_count;

	modport source (
		output valid, status, sender_id, sequence_res, voltage_x100, temperature_x100,
		       received_check, computed_check, good_count, bad_count,
		input  ready
	);
	modport sink (
		input  valid, status, sender_id, sequence_res, voltage_x100, temperature_x100,
		       received_check, computed_check, good_count, bad_count,
		output ready
	);
endinterface

/* hw/rtl/telemetry_frame_crc_checker.sv */
// ---------------------------------------------------------------------------
// telemetry_frame_crc_checker
// Per-byte frame parser: CRC-16 over the header and payload, field capture,
// length/CRC status and wrapping good/bad frame counters.
// ---------------------------------------------------------------------------
// Path: input register, byte-wide CRC update and field capture, result register.
// Throughput: one byte per cycle, but a frame's last byte waits in the input
//   register while an earlier result is still pending unread.
// Reset: position 0, CRC 0xFFFF, captured fields and both counters cleared,
//   no result pending.
module telemetry_frame_crc_checker (
	input  logic              clk,
	input  logic              arst_n,
	tfcc_in_if.sink           pkt,
	tfcc_out_if.source        res
);

	localparam int PW = tfcc_pkg::POS_W;

	// input register
	logic                 v_s1;
	tfcc_pkg::in_item_t   item_s1;

	// frame state
	logic [PW-1:0]        pos_q;
	logic [15:0]          crc_q;
	logic [7:0]           id_q;
	logic [15:0]          seq_q;
	logic [15:0]          vlt_q;
	logic [15:0]          tmp_q;
	logic [15:0]          chk_q;
	logic [31:0]          good_q;
	logic [31:0]          bad_q;

	// result register
	logic                 out_v_q;
	tfcc_pkg::result_t    out_q;

	logic                 s1_adv;
	logic                 out_load;
	logic [15:0]          crc_nx;
	logic [7:0]           id_nx;
	logic [15:0]          seq_nx;
	logic [15:0]          vlt_nx;
	logic [15:0]          tmp_nx;
	logic [15:0]          chk_nx;
	tfcc_pkg::status_t    status_nx;

	assign s1_adv   = v_s1 && (!item_s1.end_of_packet || !out_v_q || res.ready);
	assign out_load = s1_adv && item_s1.end_of_packet;
	assign pkt.ready = !v_s1 || s1_adv;

	always_comb begin
		crc_nx = crc_q;
		id_nx  = id_q;
		seq_nx = seq_q;
		vlt_nx = vlt_q;
		tmp_nx = tmp_q;
		chk_nx = chk_q;
		if (pos_q < PW'(tfcc_pkg::CRC_SPAN)) begin
			crc_nx = tfcc_pkg::crc_byte(crc_q, item_s1.rx_byte);
		end
		case (pos_q)
			tfcc_pkg::POS_ID:    id_nx         = item_s1.rx_byte;
			tfcc_pkg::POS_SEQ_H: seq_nx[15:8]  = item_s1.rx_byte;
			tfcc_pkg::POS_SEQ_L: seq_nx[7:0]   = item_s1.rx_byte;
			tfcc_pkg::POS_VLT_H: vlt_nx[15:8]  = item_s1.rx_byte;
			tfcc_pkg::POS_VLT_L: vlt_nx[7:0]   = item_s1.rx_byte;
			tfcc_pkg::POS_TMP_H: tmp_nx[15:8]  = item_s1.rx_byte;
			tfcc_pkg::POS_TMP_L: tmp_nx[7:0]   = item_s1.rx_byte;
			tfcc_pkg::POS_CRC_H: chk_nx[15:8]  = item_s1.rx_byte;
			tfcc_pkg::POS_CRC_L: chk_nx[7:0]   = item_s1.rx_byte;
			default: ;
		endcase
		if (pos_q != tfcc_pkg::POS_LAST) begin
			status_nx = tfcc_pkg::ST_BAD_LEN;
		end else if (crc_nx == chk_nx) begin
			status_nx = tfcc_pkg::ST_GOOD;
		end else begin
			status_nx = tfcc_pkg::ST_CRC_ERR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (pkt.ready) begin
			v_s1 <= pkt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt.ready && pkt.valid) begin
			item_s1.rx_byte       <= pkt.rx_byte;
			item_s1.end_of_packet <= pkt.end_of_packet;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			crc_q  <= tfcc_pkg::CRC_INIT;
			id_q   <= '0;
			seq_q  <= '0;
			vlt_q  <= '0;
			tmp_q  <= '0;
			chk_q  <= '0;
			good_q <= '0;
			bad_q  <= '0;
		end else if (s1_adv) begin
			id_q  <= id_nx;
			seq_q <= seq_nx;
			vlt_q <= vlt_nx;
			tmp_q <= tmp_nx;
			chk_q <= chk_nx;
			if (item_s1.end_of_packet) begin
				pos_q <= '0;
				crc_q <= tfcc_pkg::CRC_INIT;
				if (status_nx == tfcc_pkg::ST_GOOD) begin
					good_q <= good_q + 32'd1;
				end else begin
					bad_q <= bad_q + 32'd1;
				end
			end else begin
				crc_q <= crc_nx;
				if (pos_q < PW'(tfcc_pkg::POS_SAT)) begin
					pos_q <= pos_q + PW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_load) begin
			out_v_q <= 1'b1;
		end else if (res.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.status           <= status_nx;
			out_q.sender_id        <= id_nx;
			out_q.sequence_res     <= seq_nx;
			out_q.voltage_x100     <= vlt_nx;
			out_q.temperature_x100 <= tmp_nx;
			out_q.received_check   <= chk_nx;
			out_q.computed_check   <= crc_nx;
			out_q.good_count       <= (status_nx == tfcc_pkg::ST_GOOD) ? good_q + 32'd1 : good_q;
			out_q.bad_count        <= (status_nx == tfcc_pkg::ST_GOOD) ? bad_q : bad_q + 32'd1;
		end
	end

	assign res.valid            = out_v_q;
	assign res.status           = out_q.status;
	assign res.sender_id        = out_q.sender_id;
	assign res.sequence_res     = out_q.sequence_res;
	assign res.voltage_x100     = out_q.voltage_x100;
	assign res.temperature_x100 = out_q.temperature_x100;
	assign res.received_check   = out_q.received_check;
	assign res.computed_check   = out_q.computed_check;
	assign res.good_count       = out_q.good_count;
	assign res.bad_count        = out_q.bad_count;

	// position never runs past saturation
	a_pos_sat: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= PW'(tfcc_pkg::POS_SAT))
		else $error("byte position past saturation");

	// a frame end restarts position and CRC
	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (pos_q == '0) && (crc_q == tfcc_pkg::CRC_INIT))
		else $error("frame state not restarted after last byte");

	// each result moves exactly one counter by one
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (good_q + bad_q) == ($past(good_q) + $past(bad_q) + 32'd1))
		else $error("frame counters out of step");

	// a good status only with matching checks
	a_good_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> (out_q.status != tfcc_pkg::ST_GOOD)
			|| (out_q.computed_check == out_q.received_check))
		else $error("good status with mismatched CRC");

	// a pending result is never overwritten
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !res.ready) |-> !out_load)
		else $error("result overwritten while pending");

endmodule

/* dv/testbench.sv */
// ---------------------------------------------------------------------------
// testbench
// Random and directed byte streams into the telemetry frame checker. A
// scoreboard tracks frame position, CRC-16, field capture and counters,
// and checks every frame report against the expected one, in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_BYTES = 212;

	class frame_scoreboard;
		logic [tfcc_pkg::POS_W-1:0] pos;
		logic [15:0]                crc_acc;
		logic [7:0]                 id_q;
		logic [15:0]                seq_q;
		logic [15:0]                volt_q;
		logic [15:0]                temp_q;
		logic [15:0]                check_q;
		logic [31:0]                good_q;
		logic [31:0]                bad_q;
		tfcc_pkg::result_t          reports_due[$];
		int                         mismatches;

		function new();
			pos = '0;
			crc_acc = 16'hFFFF;
			id_q = '0;
			seq_q = '0;
			volt_q = '0;
			temp_q = '0;
			check_q = '0;
			good_q = '0;
			bad_q = '0;
			mismatches = 0;
		endfunction

		// bit-serial form: feedback is lsb of register xor next data bit
		static function logic [15:0] crc_update(logic [15:0] crc, logic [7:0] b);
			logic [15:0] c;
			logic        fb;
			int          k;
			c = crc;
			for (k = 0; k < 8; k++) begin
				fb = c[0] ^ b[k];
				c = c >> 1;
				if (fb)
					c = c ^ 16'hA001;
			end
			return c;
		endfunction

		function string show(tfcc_pkg::result_t r);
			return $sformatf("st=%0d id=%02h seq=%04h v=%0d t=%0d rx=%04h crc=%04h g=%0d b=%0d",
				r.status, r.sender_id, r.sequence_res, r.voltage_x100, r.temperature_x100,
				r.received_check, r.computed_check, r.good_count, r.bad_count);
		endfunction

		function void note_byte(logic [7:0] b, logic last);
			logic [tfcc_pkg::POS_W-1:0] at;
			tfcc_pkg::result_t          r;
			at = pos;
			if (at < tfcc_pkg::CRC_SPAN)
				crc_acc = crc_update(crc_acc, b);
			case (at)
				tfcc_pkg::POS_ID:    id_q = b;
				tfcc_pkg::POS_SEQ_H: seq_q[15:8] = b;
				tfcc_pkg::POS_SEQ_L: seq_q[7:0] = b;
				tfcc_pkg::POS_VLT_H: volt_q[15:8] = b;
				tfcc_pkg::POS_VLT_L: volt_q[7:0] = b;
				tfcc_pkg::POS_TMP_H: temp_q[15:8] = b;
				tfcc_pkg::POS_TMP_L: temp_q[7:0] = b;
				tfcc_pkg::POS_CRC_H: check_q[15:8] = b;
				tfcc_pkg::POS_CRC_L: check_q[7:0] = b;
				default: ;
			endcase
			if (at < tfcc_pkg::POS_SAT)
				pos = at + 1'b1;
			if (last) begin
				if (at != tfcc_pkg::POS_LAST) begin
					r.status = tfcc_pkg::ST_BAD_LEN;
					bad_q++;
				end else if (crc_acc == check_q) begin
					r.status = tfcc_pkg::ST_GOOD;
					good_q++;
				end else begin
					r.status = tfcc_pkg::ST_CRC_ERR;
					bad_q++;
				end
				r.sender_id = id_q;
				r.sequence_res = seq_q;
				r.voltage_x100 = volt_q;
				r.temperature_x100 = temp_q;
				r.received_check = check_q;
				r.computed_check = crc_acc;
				r.good_count = good_q;
				r.bad_count = bad_q;
				reports_due.push_back(r);
				pos = '0;
				crc_acc = 16'hFFFF;
			end
		endfunction

		function void check_result(tfcc_pkg::result_t got);
			tfcc_pkg::result_t want;
			logic              differs;
			if (reports_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: report with none pending: %s", $time, show(got));
				return;
			end
			want = reports_due.pop_front();
			differs = (got.status !== want.status)
				|| (got.sender_id !== want.sender_id)
				|| (got.sequence_res !== want.sequence_res)
				|| (got.voltage_x100 !== want.voltage_x100)
				|| (got.temperature_x100 !== want.temperature_x100)
				|| (got.received_check !== want.received_check)
				|| (got.computed_check !== want.computed_check)
				|| (got.good_count !== want.good_count)
				|| (got.bad_count !== want.bad_count);
			if (differs) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: report mismatch", $time);
					$display("  expected %s", show(want));
					$display("  actual   %s", show(got));
				end
			end
		endfunction

		function int pending();
			return reports_due.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	tfcc_in_if  pkt_if();
	tfcc_out_if res_if();

	telemetry_frame_crc_checker uut (
		.clk    (clk),
		.arst_n (arst_n),
		.pkt    (pkt_if),
		.res    (res_if)
	);

	frame_scoreboard sb;
	int              send_idle_pct;
	int              rx_stall_pct;
	logic            hold_active;
	event            long_hold;
	logic [7:0]      pkt_bytes [0:31];

	initial clk = 1'b0;
	always #4 clk = ~clk;

	initial begin
		arst_n <= 1'b0;
		pkt_if.valid <= 1'b0;
		pkt_if.rx_byte <= 8'h00;
		pkt_if.end_of_packet <= 1'b0;
		res_if.ready <= 1'b0;
		hold_active <= 1'b0;
	end

	// receiver back-pressure
	initial begin
		forever begin
			@(posedge clk);
			if (hold_active)
				res_if.ready <= 1'b0;
			else
				res_if.ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	initial begin
		forever begin
			@(long_hold);
			@(posedge clk);
			hold_active <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_active <= 1'b0;
		end
	end

	always @(posedge clk) begin
		tfcc_pkg::result_t got;
		if (arst_n) begin
			if (pkt_if.valid && pkt_if.ready)
				sb.note_byte(pkt_if.rx_byte, pkt_if.end_of_packet);
			if (res_if.valid && res_if.ready) begin
				got.status = tfcc_pkg::status_t'(res_if.status);
				got.sender_id = res_if.sender_id;
				got.sequence_res = res_if.sequence_res;
				got.voltage_x100 = res_if.voltage_x100;
				got.temperature_x100 = res_if.temperature_x100;
				got.received_check = res_if.received_check;
				got.computed_check = res_if.computed_check;
				got.good_count = res_if.good_count;
				got.bad_count = res_if.bad_count;
				sb.check_result(got);
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			pkt_if.valid <= 1'b0;
			@(posedge clk);
		end
		pkt_if.valid <= 1'b1;
		pkt_if.rx_byte <= b;
		pkt_if.end_of_packet <= last;
		@(posedge clk);
		while (!pkt_if.ready)
			@(posedge clk);
	endtask

	task automatic send_packet(input int len);
		int i;
		for (i = 0; i < len; i++)
			send_byte(pkt_bytes[i], i == len - 1);
	endtask

	// well-formed frame in pkt_bytes[0..11], check bytes big-endian
	task automatic fill_frame(input logic [23:0] hdr, input logic [7:0] id,
		input logic [15:0] seq, input logic [15:0] volt, input logic [15:0] temp);
		logic [15:0] crc;
		int          i;
		pkt_bytes[0] = hdr[23:16];
		pkt_bytes[1] = hdr[15:8];
		pkt_bytes[2] = hdr[7:0];
		pkt_bytes[3] = id;
		pkt_bytes[4] = seq[15:8];
		pkt_bytes[5] = seq[7:0];
		pkt_bytes[6] = volt[15:8];
		pkt_bytes[7] = volt[7:0];
		pkt_bytes[8] = temp[15:8];
		pkt_bytes[9] = temp[7:0];
		crc = 16'hFFFF;
		for (i = 0; i < 10; i++)
			crc = frame_scoreboard::crc_update(crc, pkt_bytes[i]);
		pkt_bytes[10] = crc[15:8];
		pkt_bytes[11] = crc[7:0];
	endtask

	function automatic logic [15:0] pick_word();
		case ($urandom_range(9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h8000;
			3: return 16'h7FFF;
			default: return 16'($urandom_range(65535));
		endcase
	endfunction

	task automatic send_random_packet(output int len);
		int kind;
		int i;
		int at;
		kind = $urandom_range(99);
		fill_frame(24'($urandom()), 8'(pick_word()), pick_word(), pick_word(), pick_word());
		len = 12;
		if (kind < 55) begin
			len = 12;
		end else if (kind < 72) begin
			// single bit flip is always caught by the CRC
			at = $urandom_range(11);
			pkt_bytes[at] = pkt_bytes[at] ^ (8'h01 << $urandom_range(7));
		end else if (kind < 84) begin
			len = $urandom_range(1, 11);
		end else if (kind < 95) begin
			len = $urandom_range(13, 20);
			for (i = 12; i < len; i++)
				pkt_bytes[i] = 8'($urandom());
		end else begin
			len = $urandom_range(1, 24);
			for (i = 0; i < len; i++)
				pkt_bytes[i] = 8'($urandom());
		end
		send_packet(len);
	endtask

	initial begin
		int ph;
		int sent;
		int n;
		int i;
		int idle_tbl [4];
		int stall_tbl [4];
		idle_tbl = '{0, 53, 0, 16};
		stall_tbl = '{0, 0, 53, 16};
		sb = new();
		send_idle_pct = 0;
		rx_stall_pct = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extreme field values, then a single-byte packet, then an overlong
		// packet whose first twelve bytes form a good frame
		fill_frame(24'h00FF00, 8'hFF, 16'hFFFF, 16'h8000, 16'h7FFF);
		send_packet(12);
		pkt_bytes[0] = 8'hFF;
		send_packet(1);
		fill_frame(24'hFF00FF, 8'h00, 16'h0000, 16'hFFFF, 16'h8000);
		pkt_bytes[12] = 8'hA5;
		send_packet(13);

		for (ph = 0; ph < 4; ph++) begin
			send_idle_pct = idle_tbl[ph];
			rx_stall_pct = stall_tbl[ph];
			sent = 0;
			if (ph == 0) begin
				// fill the block while results are held back
				-> long_hold;
				for (i = 0; i < 6; i++) begin
					fill_frame(24'($urandom()), 8'($urandom()), pick_word(), pick_word(),
						pick_word());
					send_packet(12);
					sent += 12;
				end
			end
			while (sent < PHASE_BYTES) begin
				send_random_packet(n);
				sent += n;
			end
		end
		pkt_if.valid <= 1'b0;

		while (sb.pending() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

	initial begin
		#2ms;
		$display("testbench NOT OK");
		$finish;
	end

endmodule

/* files.f */
hw/rtl/tfcc_pkg.sv
hw/rtl/tfcc_if.sv
hw/rtl/telemetry_frame_crc_checker.sv
dv/testbench.sv
